// ----- design/picr_pkg.sv -----
// Package with shared types and constants for the point-in-region engine.
package picr_pkg;

    // Operation codes carried in the opcode field.
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_POINT  = 3'd2;
    localparam logic [2:0] OP_TRI    = 3'd3;
    localparam logic [2:0] OP_BOX    = 3'd4;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPEND,
        ST_REGION,
        ST_FIRST,
        ST_EDGE,
        ST_MUL,
        ST_DECIDE,
        ST_BOX,
        ST_DONE
    } state_t;

    // One edge handed from the sequencer to the edge test unit.
    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } edge_t;

endpackage

// ----- design/picr_if.sv -----
// Valid/ready channel interface used for the input and result streams.
interface picr_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/picr_edge.sv -----
// Edge crossing test: combinational conditions, registered products, then the decision.
module picr_edge (
    input  logic            clk,
    input  picr_pkg::edge_t e,
    output logic            pre_pass,
    output logic            vert,
    output logic            crosses
);
    import picr_pkg::*;

    logic signed [32:0] dy, dx, lx, ly;
    logic signed [65:0] lhs_reg, rhs_reg;
    logic               dy_pos_reg;
    logic signed [31:0] lo, hi, xmax;

    // Range conditions of the crossing-number test.
    always_comb
    begin
        lo   = (e.ay < e.by) ? e.ay : e.by;
        hi   = (e.ay < e.by) ? e.by : e.ay;
        xmax = (e.ax < e.bx) ? e.bx : e.ax;
        pre_pass = (e.py > lo) && (e.py <= hi) && (e.px <= xmax) && (e.ay != e.by);
        vert = (e.ax == e.bx);
        dy = 33'(e.by) - 33'(e.ay);
        dx = 33'(e.bx) - 33'(e.ax);
        lx = 33'(e.px) - 33'(e.ax);
        ly = 33'(e.py) - 33'(e.ay);
    end

    // Cross products, registered before the compare.
    always_ff @(posedge clk)
    begin
        lhs_reg    <= 66'(lx) * 66'(dy);
        rhs_reg    <= 66'(ly) * 66'(dx);
        dy_pos_reg <= (dy > 0);
    end

    // px - ax <= (py - ay) * dx / dy, sign of dy folded in.
    assign crosses = dy_pos_reg ? (lhs_reg <= rhs_reg) : (lhs_reg >= rhs_reg);
endmodule

// ----- design/point_in_convex_regions.sv -----
// Top level of the point-in-region engine.
// Each word is one operation and returns one result word. A new word is taken once
// the sequencer is back in idle. A finished result moves into an output register,
// so a stalled result side holds the sequencer only when the next result is ready
// too. An append updates the count, the box and the vertex memory at the accepting
// edge and then passes through the append state to done; a clear resets the count
// at that edge and goes straight to done. A point query visits the regions in index
// order. A region that is empty, or whose box misses the point, is passed over from
// the region state. A region that is walked reads its first vertex and then, per
// edge, the next vertex from the vertex memory, and each edge goes through the edge,
// multiply and decide states (operands, registered products, decision). A point
// query stops at the first hit. A triangle query is up to three point walks. A box
// query examines the regions in index order and stops at the first overlap. At
// default sizes the worst case is three full walks of 8 regions of 32 vertices.
module point_in_convex_regions #(
    parameter int NUM_REGIONS  = 8,
    parameter int MAX_VERTICES = 32,
    parameter int COORD_WIDTH  = 32
) (
    input  logic clk,
    input  logic rst_n,
    picr_if.sink   in_ch,
    picr_if.source out_ch
);
    import picr_pkg::*;

    localparam int RW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = RW + VW;

    // Input word fields.
    logic [2:0]  opcode;
    logic [2:0]  region;
    logic [31:0] x0, y0, x1, y1, x2, y2;
    assign {opcode, region, x0, y0, x1, y1, x2, y2} = in_ch.data;

    function automatic logic signed [31:0] cvt(input logic [31:0] v);
        return 32'(signed'(v[COORD_WIDTH-1:0]));
    endfunction

    // Vertex memory, one entry holds x and y.
    logic [63:0] vmem [NUM_REGIONS*MAX_VERTICES];
    logic [63:0] vrd_reg;
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic [63:0]   wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            vmem[waddr] <= wdata;
        end
        vrd_reg <= vmem[raddr];
    end

    // Per-region count and box.
    logic [CW-1:0] cnt_reg [NUM_REGIONS];
    logic signed [31:0] bminx_reg [NUM_REGIONS];
    logic signed [31:0] bminy_reg [NUM_REGIONS];
    logic signed [31:0] bmaxx_reg [NUM_REGIONS];
    logic signed [31:0] bmaxy_reg [NUM_REGIONS];

    state_t state_reg, state_next;
    logic [2:0]  op_reg;
    logic [RW-1:0] reg_idx_reg;
    logic [CW:0] vi_reg;
    logic [1:0]  pt_reg;
    logic signed [31:0] px_reg, py_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [31:0] qx_reg [3];
    logic signed [31:0] qy_reg [3];
    logic signed [32:0] ex_reg, ey_reg;
    logic        par_reg, hit_reg, status_reg, out_valid_reg, out_valid_next;
    logic        res_hit_reg, res_status_reg;
    logic        pre_reg, vert_reg;

    edge_t e;
    logic  pre_pass, vert, crosses;
    assign e = '{ax_reg, ay_reg, bx_reg, by_reg, px_reg, py_reg};

    picr_edge u_edge (.clk(clk), .e(e), .pre_pass(pre_pass), .vert(vert),
        .crosses(crosses));

    logic [RW-1:0] ar;
    assign ar = region[RW-1:0];
    logic rvalid;
    assign rvalid = (32'(region) < NUM_REGIONS);

    // Box test of the current region against the current point.
    logic box_in, last_region, reg_empty;
    assign reg_empty = (cnt_reg[reg_idx_reg] == '0);
    assign box_in = !(bminx_reg[reg_idx_reg] > px_reg || bminy_reg[reg_idx_reg] > py_reg ||
                      bmaxx_reg[reg_idx_reg] < px_reg || bmaxy_reg[reg_idx_reg] < py_reg);
    assign last_region = (32'(reg_idx_reg) == NUM_REGIONS - 1);
    logic box_ov;
    assign box_ov = (33'(bminx_reg[reg_idx_reg]) <= ex_reg) && (bmaxx_reg[reg_idx_reg] > px_reg) &&
                    (33'(bminy_reg[reg_idx_reg]) <= ey_reg) && (bmaxy_reg[reg_idx_reg] > py_reg);
    logic last_pt;
    assign last_pt = (op_reg != OP_TRI) || (pt_reg == 2'd2);
    // The next edge closes the polygon back to vertex zero.
    logic edge_last;
    assign edge_last = (vi_reg == (CW+1)'(cnt_reg[reg_idx_reg]));
    // Every edge of the region has been decided.
    logic edge_done;
    assign edge_done = (vi_reg == (CW+1)'(cnt_reg[reg_idx_reg]) + 1'b1);
    logic par_fin;
    assign par_fin = par_reg ^ (pre_reg && (vert_reg || crosses));

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = {res_hit_reg, res_status_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_ch.valid)
                begin
                    unique case (opcode) inside
                        OP_APPEND:       state_next = ST_APPEND;
                        OP_POINT, OP_TRI: state_next = ST_REGION;
                        OP_BOX:          state_next = ST_BOX;
                        default:         state_next = ST_DONE;
                    endcase
                end
            ST_APPEND: state_next = ST_DONE;
            ST_REGION:
                if (!reg_empty && box_in) state_next = ST_FIRST;
                else if (last_region) state_next = last_pt ? ST_DONE : ST_REGION;
            ST_FIRST:  state_next = ST_EDGE;
            ST_EDGE:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_DECIDE;
            ST_DECIDE:
                if (!edge_done) state_next = ST_EDGE;
                else if (par_fin || last_region) state_next = (par_fin || last_pt) ? ST_DONE : ST_REGION;
                else state_next = ST_REGION;
            ST_BOX:
                if ((!reg_empty && box_ov) || last_region) state_next = ST_DONE;
            ST_DONE:
                if (!out_valid_reg || out_ch.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register: loaded from the done state, emptied when taken.
    always_comb
    begin
        if (state_reg == ST_DONE && (!out_valid_reg || out_ch.ready))
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Memory port control.
    always_comb
    begin
        we    = (state_reg == ST_IDLE) && in_ch.valid && (opcode == OP_APPEND) && rvalid
                && (cnt_reg[ar] < CW'(MAX_VERTICES));
        waddr = AW'(32'(ar) * MAX_VERTICES + 32'(cnt_reg[ar]));
        wdata = {cvt(x0), cvt(y0)};
        raddr = AW'(32'(reg_idx_reg) * MAX_VERTICES
                + ((state_reg == ST_REGION || edge_last) ? 0 : 32'(vi_reg)));
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGIONS; i++) cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_IDLE:
                    if (in_ch.valid)
                    begin
                        op_reg <= opcode; hit_reg <= 1'b0; status_reg <= 1'b0;
                        reg_idx_reg <= '0; pt_reg <= '0;
                        qx_reg[0] <= cvt(x0); qy_reg[0] <= cvt(y0);
                        qx_reg[1] <= cvt(x1); qy_reg[1] <= cvt(y1);
                        qx_reg[2] <= cvt(x2); qy_reg[2] <= cvt(y2);
                        px_reg <= cvt(x0); py_reg <= cvt(y0);
                        ex_reg <= 33'(cvt(x0)) + 33'(cvt(x1));
                        ey_reg <= 33'(cvt(y0)) + 33'(cvt(y1));
                        if (opcode == OP_CLEAR && rvalid) cnt_reg[ar] <= '0;
                        if (opcode == OP_APPEND && rvalid)
                        begin
                            if (cnt_reg[ar] >= CW'(MAX_VERTICES)) status_reg <= 1'b1;
                            else
                            begin
                                cnt_reg[ar] <= cnt_reg[ar] + 1'b1;
                                if (cnt_reg[ar] == '0 || cvt(x0) < bminx_reg[ar]) bminx_reg[ar] <= cvt(x0);
                                if (cnt_reg[ar] == '0 || cvt(y0) < bminy_reg[ar]) bminy_reg[ar] <= cvt(y0);
                                if (cnt_reg[ar] == '0 || cvt(x0) > bmaxx_reg[ar]) bmaxx_reg[ar] <= cvt(x0);
                                if (cnt_reg[ar] == '0 || cvt(y0) > bmaxy_reg[ar]) bmaxy_reg[ar] <= cvt(y0);
                            end
                        end
                    end
                ST_REGION:
                begin
                    vi_reg <= (CW+1)'(1); par_reg <= 1'b0;
                    if (!(!reg_empty && box_in))
                    begin
                        reg_idx_reg <= last_region ? '0 : reg_idx_reg + 1'b1;
                        if (last_region && !last_pt)
                        begin
                            pt_reg <= pt_reg + 1'b1;
                            px_reg <= qx_reg[pt_reg + 1'b1]; py_reg <= qy_reg[pt_reg + 1'b1];
                        end
                    end
                end
                ST_FIRST:
                begin
                    ax_reg <= vrd_reg[63:32]; ay_reg <= vrd_reg[31:0];
                end
                ST_EDGE:
                begin
                    bx_reg <= vrd_reg[63:32]; by_reg <= vrd_reg[31:0];
                end
                ST_MUL:
                begin
                    pre_reg <= pre_pass; vert_reg <= vert;
                    vi_reg <= vi_reg + 1'b1;
                end
                ST_DECIDE:
                begin
                    par_reg <= par_fin;
                    ax_reg <= bx_reg; ay_reg <= by_reg;
                    if (edge_done)
                    begin
                        if (par_fin) hit_reg <= 1'b1;
                        else
                        begin
                            reg_idx_reg <= last_region ? '0 : reg_idx_reg + 1'b1;
                            if (last_region && !last_pt)
                            begin
                                pt_reg <= pt_reg + 1'b1;
                                px_reg <= qx_reg[pt_reg + 1'b1]; py_reg <= qy_reg[pt_reg + 1'b1];
                            end
                        end
                    end
                end
                ST_BOX:
                begin
                    if (!reg_empty && box_ov) hit_reg <= 1'b1;
                    reg_idx_reg <= reg_idx_reg + 1'b1;
                end
                ST_DONE:
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        res_hit_reg    <= hit_reg;
                        res_status_reg <= status_reg;
                    end
                default: ;
            endcase
        end
    end

    // Result words are only raised from the done state.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside done state");
    // An append that writes memory never reports a full region.
    a_we_status: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> !status_reg)
        else $error("write with full status");
    // The count of region zero never exceeds the store depth.
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CW'(MAX_VERTICES))
        else $error("count overflow");
endmodule

// ----- verif/picr_tb_scoreboard.sv -----
// Scoreboard class that predicts and checks the point-in-region engine results.
package picr_tb_pkg;
    import picr_pkg::*;

    // One operation word as the testbench sees it.
    typedef struct {
        logic [2:0]  opcode;
        logic [2:0]  region;
        logic signed [31:0] x0, y0, x1, y1, x2, y2;
    } op_word_t;

    // One result word.
    typedef struct {
        logic hit;
        logic status;
    } result_word_t;

    class region_scoreboard;
        localparam int NREG = 8;
        localparam int NVTX = 32;

        // Shadow copy of the region store.
        longint vx[NREG][NVTX];
        longint vy[NREG][NVTX];
        int     vcount[NREG];
        longint bmin_x[NREG], bmin_y[NREG], bmax_x[NREG], bmax_y[NREG];

        result_word_t pending[$];
        int errors;
        int results_seen;
        int hits_seen;
        int drops_seen;

        function new();
            errors = 0;
            results_seen = 0;
            hits_seen = 0;
            drops_seen = 0;
            foreach (vcount[i])
                vcount[i] = 0;
        endfunction

        // Crossing-number test of one region, with an exact cross-multiplied edge test.
        function bit region_holds(int r, longint px, longint py);
            int crossings;
            int k;
            longint ax, ay, bx, by, lo, hi, xmax;
            logic signed [69:0] lhs, rhs;
            crossings = 0;
            ax = vx[r][0];
            ay = vy[r][0];
            for (int i = 1; i <= vcount[r]; i++)
            begin
                k = (i == vcount[r]) ? 0 : i;
                bx = vx[r][k];
                by = vy[r][k];
                lo = (ay < by) ? ay : by;
                hi = (ay < by) ? by : ay;
                xmax = (ax < bx) ? bx : ax;
                if (py > lo && py <= hi && px <= xmax && ay != by)
                begin
                    if (ax == bx)
                        crossings++;
                    else
                    begin
                        lhs = 70'(px - ax) * 70'(by - ay);
                        rhs = 70'(py - ay) * 70'(bx - ax);
                        if ((by > ay) ? (lhs <= rhs) : (lhs >= rhs))
                            crossings++;
                    end
                end
                ax = bx;
                ay = by;
            end
            return crossings[0];
        endfunction

        // Walk the non-empty regions whose box holds the point, up to the first that holds it.
        function bit any_region_holds(longint px, longint py);
            for (int r = 0; r < NREG; r++)
            begin
                if (vcount[r] == 0)
                    continue;
                if (bmin_x[r] > px || bmin_y[r] > py || bmax_x[r] < px || bmax_y[r] < py)
                    continue;
                if (region_holds(r, px, py))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Apply an accepted operation word and queue its expected result.
        function void note_word(op_word_t w);
            result_word_t res;
            longint ex, ey;
            int n;
            res.hit = 1'b0;
            res.status = 1'b0;
            case (w.opcode)
                OP_CLEAR:
                    vcount[w.region] = 0;
                OP_APPEND:
                begin
                    n = vcount[w.region];
                    if (n >= NVTX)
                        res.status = 1'b1;
                    else
                    begin
                        vx[w.region][n] = w.x0;
                        vy[w.region][n] = w.y0;
                        if (n == 0)
                        begin
                            bmin_x[w.region] = w.x0;
                            bmax_x[w.region] = w.x0;
                            bmin_y[w.region] = w.y0;
                            bmax_y[w.region] = w.y0;
                        end
                        else
                        begin
                            if (w.x0 < bmin_x[w.region]) bmin_x[w.region] = w.x0;
                            if (w.y0 < bmin_y[w.region]) bmin_y[w.region] = w.y0;
                            if (w.x0 > bmax_x[w.region]) bmax_x[w.region] = w.x0;
                            if (w.y0 > bmax_y[w.region]) bmax_y[w.region] = w.y0;
                        end
                        vcount[w.region] = n + 1;
                    end
                end
                OP_POINT:
                    res.hit = any_region_holds(w.x0, w.y0);
                OP_TRI:
                    res.hit = any_region_holds(w.x0, w.y0) || any_region_holds(w.x1, w.y1)
                              || any_region_holds(w.x2, w.y2);
                OP_BOX:
                begin
                    // Origin plus size at full precision.
                    ex = longint'(w.x0) + longint'(w.x1);
                    ey = longint'(w.y0) + longint'(w.y1);
                    for (int r = 0; r < NREG; r++)
                    begin
                        if (vcount[r] != 0 && bmin_x[r] <= ex && bmax_x[r] > w.x0
                            && bmin_y[r] <= ey && bmax_y[r] > w.y0)
                        begin
                            res.hit = 1'b1;
                            break;
                        end
                    end
                end
                default:
                    ;
            endcase
            pending = {pending, res};
        endfunction

        // Compare one accepted result word with the oldest expectation.
        function void check_result(result_word_t got);
            result_word_t want;
            results_seen++;
            if (got.hit) hits_seen++;
            if (got.status) drops_seen++;
            if (pending.size() == 0)
            begin
                $error("result word with no expectation: hit=%0b status=%0b", got.hit, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit)
            begin
                $error("hit: expected %0b, actual %0b", want.hit, got.hit);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0b, actual %0b", want.status, got.status);
                errors++;
            end
        endfunction
    endclass
endpackage

// ----- verif/tb.sv -----
// Testbench top for the point-in-region engine.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import picr_pkg::*;
    import picr_tb_pkg::*;

    localparam int IN_W = 198;
    localparam int OUT_W = 2;
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic clk;
    logic rst_n;
    longint cycles;
    int words_sent;
    bit no_idle;

    picr_if #(.W(IN_W))  in_ch ();
    picr_if #(.W(OUT_W)) out_ch ();

    region_scoreboard sb;

    point_in_convex_regions uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Monitor both channels at the rising edge.
    always @(posedge clk)
    begin
        op_word_t w;
        result_word_t r;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            {w.opcode, w.region, w.x0, w.y0, w.x1, w.y1, w.x2, w.y2} = in_ch.data;
            sb.note_word(w);
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            {r.hit, r.status} = out_ch.data;
            sb.check_result(r);
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stalls per word, with stretches of none.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            @(negedge clk);
            out_ch.ready = 1'b0;
            repeat (stall) @(negedge clk);
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // Send one operation word after a random gap.
    task automatic send_word(logic [2:0] op, logic [2:0] rg, logic [31:0] x0, logic [31:0] y0,
                             logic [31:0] x1, logic [31:0] y1, logic [31:0] x2,
                             logic [31:0] y2);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data = {op, rg, x0, y0, x1, y1, x2, y2};
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        words_sent++;
    endtask

    // Wait for every expected result to arrive.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] near_coord();
        return 32'($urandom_range(0, 16000)) - 32'd8000;
    endfunction

    // Clear a region and append a convex polygon around a center.
    task automatic build_region(logic [2:0] rg, int cx, int cy, int rad, int sides);
        int dx[8] = '{2, 1, 0, -1, -2, -1, 0, 1};
        int dy[8] = '{0, 1, 2, 1, 0, -1, -2, -1};
        int step;
        send_word(OP_CLEAR, rg, 0, 0, 0, 0, 0, 0);
        step = 8 / sides;
        for (int i = 0; i < sides; i++)
            send_word(OP_APPEND, rg, cx + dx[i * step] * rad, cy + dy[i * step] * rad,
                      $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        int sel;
        logic [31:0] px, py;
        sb = new();
        cycles = 0;
        words_sent = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: queries on empty store, a square with horizontal and vertical edges.
        send_word(OP_POINT, 3'd0, 0, 0, 0, 0, 0, 0);
        send_word(OP_BOX, 3'd0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
        send_word(OP_APPEND, 3'd0, 0, 0, 0, 0, 0, 0);
        send_word(OP_APPEND, 3'd0, 1024, 0, 0, 0, 0, 0);
        send_word(OP_APPEND, 3'd0, 1024, 1024, 0, 0, 0, 0);
        send_word(OP_APPEND, 3'd0, 0, 1024, 0, 0, 0, 0);
        send_word(OP_POINT, 3'd0, 512, 512, 0, 0, 0, 0);
        send_word(OP_POINT, 3'd0, 0, 512, 0, 0, 0, 0);
        send_word(OP_POINT, 3'd0, 1024, 1024, 0, 0, 0, 0);
        send_word(OP_POINT, 3'd0, 512, 0, 0, 0, 0, 0);
        send_word(OP_TRI, 3'd0, -5, -5, 2000, 2000, 100, 100);
        send_word(OP_BOX, 3'd0, 1024, 1024, 5, 5, 0, 0);
        send_word(OP_BOX, 3'd0, -10, -10, 10, 10, 0, 0);
        send_word(OP_BOX, 3'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
        // Extreme coordinates in a sloped triangle, then fill the region past full.
        send_word(OP_APPEND, 3'd7, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
        send_word(OP_APPEND, 3'd7, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0);
        send_word(OP_APPEND, 3'd7, 32'h0000_0000, 32'h7fff_ffff, 0, 0, 0, 0);
        send_word(OP_POINT, 3'd0, 32'h7000_0000, 32'hc000_0000, 0, 0, 0, 0);
        send_word(OP_POINT, 3'd0, 32'hc000_0000, 32'h4000_0000, 0, 0, 0, 0);
        send_word(OP_TRI, 3'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h1000_0000, 32'h1000_0000);
        for (int i = 0; i < 30; i++)
            send_word(OP_APPEND, 3'd7, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
        send_word(OP_POINT, 3'd7, 0, 0, 0, 0, 0, 0);
        send_word(3'd5, 3'd2, 0, 0, 0, 0, 0, 0);
        send_word(3'd7, 3'd5, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff, 32'hffff_ffff);
        send_word(OP_CLEAR, 3'd7, 0, 0, 0, 0, 0, 0);

        // Let every directed result come back before random traffic.
        drain();

        // Random: polygons built in hull order mixed with appends, clears, queries near them and noise.
        while (words_sent < 1250)
        begin
            if ((words_sent / 150) % 3 == 2)
                no_idle = 1'b1;
            else
                no_idle = 1'b0;
            sel = $urandom_range(0, 99);
            px = near_coord();
            py = near_coord();
            if (sel < 12)
                build_region(3'($urandom), $signed(near_coord()), $signed(near_coord()),
                             $urandom_range(1, 3000), (1 << $urandom_range(1, 3)));
            else if (sel < 22)
                send_word(OP_APPEND, 3'($urandom), px, py, $urandom, $urandom, $urandom,
                          $urandom);
            else if (sel < 24)
                send_word(OP_CLEAR, 3'($urandom), $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
            else if (sel < 50)
                send_word(OP_POINT, 3'($urandom), px, py, $urandom, $urandom, $urandom,
                          $urandom);
            else if (sel < 68)
                send_word(OP_TRI, 3'($urandom), px, py, near_coord(), near_coord(),
                          near_coord(), near_coord());
            else if (sel < 85)
                send_word(OP_BOX, 3'($urandom), px, py, $urandom_range(0, 6000),
                          $urandom_range(0, 6000), $urandom, $urandom);
            else
                // Noise: any opcode, full-width coordinates.
                send_word(3'($urandom), 3'($urandom), $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
        end

        // Wait for the last results, then a little longer for stray words.
        drain();
        repeat (3000) @(negedge clk);
        $display("Sent %0d operation words; checked %0d results in %0d cycles.",
                 words_sent, sb.results_seen, cycles);
        $display("Results included %0d hits and %0d dropped appends.",
                 sb.hits_seen, sb.drops_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- point_in_convex_regions.f -----
design/picr_pkg.sv
design/picr_if.sv
design/picr_edge.sv
design/point_in_convex_regions.sv
verif/picr_tb_scoreboard.sv
verif/tb.sv
